>>> src/utf8sd_pkg.sv
// utf8sd_pkg: shared types and constants for the utf-8 stream decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned HeldW  = 2;
  localparam int unsigned CountW = 3;

  localparam logic [CpW-1:0]   ReplCp = 21'h00FFFD;

  localparam logic [LenW-1:0]  LenNone = 3'd0;
  localparam logic [LenW-1:0]  LenTwo  = 3'd2;
  localparam logic [LenW-1:0]  LenThree = 3'd3;
  localparam logic [LenW-1:0]  LenFour = 3'd4;

  // burst of results caused by one byte: cnt results, all replacement
  // characters except the last, which is last_cp
  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [CpW-1:0]    last_cp;
  } burst_t;

endpackage

`default_nettype wire

>>> src/utf8_stream_decoder_unit.sv
// utf8_stream_decoder_unit: top level of the utf-8 stream decoder
// depends on utf8sd_pkg, utf8sd_decode and utf8sd_burst
//
// Takes utf-8 text one byte per request and returns 21-bit code points, with
// run_end_o marking the last result caused by each byte. A byte is held in an
// input register, decoded in one pass against the pending sequence state and
// its results are loaded into a result register, from which the first result
// of a byte is offered once the byte has moved out of the input register. The
// block takes one byte per cycle while the input is not stalled; a byte that
// gives n results (n up to four, only in error bursts, all U+FFFD but the last)
// occupies the single result register until all n are taken, and the input
// stalls meanwhile. Bytes that only extend a sequence give no result. No
// overlong or surrogate checks.
`default_nettype none

module utf8_stream_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte requests
  input  logic                          text_valid_i,
  output logic                          text_stall_o,
  input  logic [utf8sd_pkg::ByteW-1:0]  text_byte_i,
  input  logic                          final_byte_i,
  // code point requests
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8sd_pkg::CpW-1:0]    code_point_o,
  output logic                          run_end_o
);
  import utf8sd_pkg::*;

  // input register
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] byte_q;
  logic             fin_q;

  logic   can_load;   // result register frees up this cycle
  logic   advance;    // registered byte moves into the result register
  logic   accept;
  burst_t dec_burst;
  burst_t load_burst;

  assign advance      = in_vld_q && can_load;
  // input holds only while the registered byte waits on the result register
  assign text_stall_o = in_vld_q && !can_load;
  assign accept       = text_valid_i && !text_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  // sequence state and single-pass decode
  utf8sd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_q),
    .final_i   (fin_q),
    .burst_o   (dec_burst)
  );

  // an empty burst is loaded when no byte is waiting, which drains the register
  assign load_burst = advance ? dec_burst : '{cnt: 3'd0, last_cp: ReplCp};

  utf8sd_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (1'b1),
    .burst_i      (load_burst),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .run_end_o    (run_end_o)
  );

endmodule

`default_nettype wire

>>> src/utf8sd_decode.sv
// utf8sd_decode: sequence state and single-pass decode of one registered byte
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [utf8sd_pkg::ByteW-1:0]    byte_i,
  input  logic                            final_i,
  output utf8sd_pkg::burst_t              burst_o
);
  import utf8sd_pkg::*;

  logic [CpW-1:0]   pv_q, pv_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [HeldW-1:0] held_q, held_d;

  logic             pending, is_cont;
  logic [CpW-1:0]   pv_app;
  logic [HeldW-1:0] held_inc;
  logic             complete;
  logic [CountW-1:0] nrep;

  assign pending  = (len_q != LenNone);
  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign pv_app   = {pv_q[CpW-7:0], byte_i[5:0]};
  assign held_inc = held_q + 2'd1;
  assign complete = ({1'b0, held_inc} + 3'd1) >= len_q;
  assign nrep     = pending ? ({1'b0, held_q} + 3'd1) : 3'd0;

  always_comb begin
    pv_d    = '0;
    len_d   = LenNone;
    held_d  = '0;
    burst_o = '{cnt: 3'd0, last_cp: ReplCp};
    if (pending && is_cont) begin
      if (complete) begin
        burst_o = '{cnt: 3'd1, last_cp: pv_app};
      end else if (final_i) begin
        // cut off: lead plus every held continuation
        burst_o = '{cnt: {1'b0, held_inc} + 3'd1, last_cp: ReplCp};
      end else begin
        pv_d   = pv_app;
        len_d  = len_q;
        held_d = held_inc;
      end
    end else begin
      // broken sequence flush (if any) then decode as a lead
      if (byte_i[7] == 1'b0) begin
        burst_o = '{cnt: nrep + 3'd1, last_cp: {13'd0, byte_i}};
      end else if (byte_i[7:5] == 3'b110 || byte_i[7:4] == 4'b1110 ||
                   byte_i[7:3] == 5'b11110) begin
        if (final_i) begin
          burst_o = '{cnt: nrep + 3'd1, last_cp: ReplCp};
        end else begin
          burst_o = '{cnt: nrep, last_cp: ReplCp};
          if (byte_i[7:5] == 3'b110) begin
            len_d = LenTwo;
            pv_d  = {16'd0, byte_i[4:0]};
          end else if (byte_i[7:4] == 4'b1110) begin
            len_d = LenThree;
            pv_d  = {17'd0, byte_i[3:0]};
          end else begin
            len_d = LenFour;
            pv_d  = {18'd0, byte_i[2:0]};
          end
        end
      end else begin
        burst_o = '{cnt: nrep + 3'd1, last_cp: ReplCp};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      len_q  <= LenNone;
      held_q <= '0;
    end else if (advance_i) begin
      pv_q   <= pv_d;
      len_q  <= len_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> src/utf8sd_burst.sv
// utf8sd_burst: result register that plays out a burst of up to four results
// depends on utf8sd_pkg
`default_nettype none

module utf8sd_burst (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_en_i,
  input  utf8sd_pkg::burst_t            burst_i,
  output logic                          can_load_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8sd_pkg::CpW-1:0]    code_point_o,
  output logic                          run_end_o
);
  import utf8sd_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CpW-1:0]    last_q, last_d;
  logic              take;

  assign out_valid_o  = (cnt_q != 3'd0);
  assign run_end_o    = (cnt_q == 3'd1);
  assign code_point_o = run_end_o ? last_q : ReplCp;
  assign take         = out_valid_o && !out_stall_i;
  assign can_load_o   = (cnt_q == 3'd0) || (run_end_o && !out_stall_i);

  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    if (load_en_i && can_load_o) begin
      cnt_d  = burst_i.cnt;
      last_d = burst_i.last_cp;
    end else if (take) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

endmodule

`default_nettype wire

>>> src/utf8sd_checker.sv
// utf8sd_checker: port-level assertions for utf8_stream_decoder_unit
// depends on utf8sd_pkg; bound to the top level at the end of this file
`default_nettype none

module utf8sd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          text_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [utf8sd_pkg::CpW-1:0]    code_point_o,
  input logic                          run_end_o
);
  import utf8sd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o) &&
    $stable(run_end_o))
    else $error("stalled result changed");

  // only the last result of a burst can be other than a replacement
  a_repl_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_end_o |-> code_point_o == ReplCp)
    else $error("non-final result is not U+FFFD");

  // a burst is not cut short
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_end_o |=> out_valid_o)
    else $error("burst ended without run_end");

  // input stalls only behind a busy result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_stall_o |-> out_valid_o && (out_stall_i || !run_end_o))
    else $error("input stalled with result register free");

endmodule

bind utf8_stream_decoder_unit utf8sd_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .text_stall_o (text_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_point_o (code_point_o),
  .run_end_o    (run_end_o)
);

`default_nettype wire

>>> dv/tb_top.sv
// tb_top: self-checking testbench for the utf-8 stream decoder unit
// depends on utf8sd_pkg and utf8_stream_decoder_unit; predicts every code point
// from its own copy of the decoder state and checks results in order
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8sd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxResults = 4;
  localparam int DrainWait  = 8;

  // one code point request as seen on the output side
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           run_end;
  } cp_result_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               text_valid_i = 1'b0;
  logic               text_stall_o;
  logic [ByteW-1:0]   text_byte_i  = '0;
  logic               final_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [CpW-1:0]     code_point_o;
  logic               run_end_o;

  utf8_stream_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_valid_i (text_valid_i),
    .text_stall_o (text_stall_o),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .run_end_o    (run_end_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // decoder state kept by the predictor
  logic [CpW-1:0]   seq_partial = '0;
  logic [LenW-1:0]  seq_len     = LenNone;
  logic [HeldW-1:0] seq_held    = '0;

  cp_result_t burst_q[$];       // results of the byte being decoded
  cp_result_t pending_cps[$];   // code points still owed by the block

  int gap_pct     = 31;   // chance of a sender idle cycle, in percent
  int stall_pct   = 31;   // chance of a receiver stall cycle, in percent
  int hold_left   = 0;    // cycles left in a long receiver hold-off
  int cycle_count = 0;
  int bytes_sent  = 0;
  int cps_checked = 0;
  int repl_seen   = 0;
  int errors      = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // a byte never yields more than four results; extras are dropped
  task automatic add_result(input logic [CpW-1:0] cp);
    cp_result_t r;
    r.cp      = cp;
    r.run_end = 1'b0;
    if (burst_q.size() < MaxResults) burst_q.push_back(r);
  endtask

  // replacement for the lead and for every held continuation byte
  task automatic flush_sequence();
    add_result(ReplCp);
    for (int i = 0; i < int'(seq_held); i++) add_result(ReplCp);
    seq_partial = '0;
    seq_len     = LenNone;
    seq_held    = '0;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic last_flag);
    logic as_lead;
    as_lead = 1'b1;
    burst_q.delete();

    if (seq_len != LenNone) begin
      if (b[7:6] == 2'b10) begin
        // continuation byte: gather six payload bits
        as_lead     = 1'b0;
        seq_partial = {seq_partial[CpW-7:0], b[5:0]};
        seq_held    = seq_held + 1'b1;
        if (int'(seq_held) + 1 >= int'(seq_len)) begin
          add_result(seq_partial);
          seq_partial = '0;
          seq_len     = LenNone;
          seq_held    = '0;
        end else if (last_flag) begin
          flush_sequence();
        end
      end else begin
        // broken sequence, the byte is then taken as a fresh lead
        flush_sequence();
      end
    end

    if (as_lead) begin
      if (b[7] == 1'b0) begin
        add_result({{(CpW-ByteW){1'b0}}, b});
      end else if (b[7:5] == 3'b110) begin
        seq_len     = LenTwo;
        seq_partial = {{(CpW-5){1'b0}}, b[4:0]};
        seq_held    = '0;
      end else if (b[7:4] == 4'b1110) begin
        seq_len     = LenThree;
        seq_partial = {{(CpW-4){1'b0}}, b[3:0]};
        seq_held    = '0;
      end else if (b[7:3] == 5'b11110) begin
        seq_len     = LenFour;
        seq_partial = {{(CpW-3){1'b0}}, b[2:0]};
        seq_held    = '0;
      end else begin
        add_result(ReplCp);
      end
      // text ends with a sequence still open
      if (last_flag && seq_len != LenNone) flush_sequence();
    end

    if (burst_q.size() > 0) burst_q[burst_q.size()-1].run_end = 1'b1;
    foreach (burst_q[i]) pending_cps.push_back(burst_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at a falling edge; valid stays high
  // so that back-to-back requests need no toggle
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last_flag);
    while ($urandom_range(99) < gap_pct) begin
      text_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    text_valid_i <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= last_flag;
    @(posedge clk_i);
    while (text_stall_o) @(posedge clk_i);
    decode_byte(b, last_flag);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic rand_last();
    return ($urandom_range(99) < 4);
  endfunction

  function automatic logic [ByteW-1:0] rand_cont();
    logic [31:0] r;
    r = $urandom;
    return {2'b10, r[5:0]};
  endfunction

  // one unit of random text: a well-formed character, a stray byte, or a
  // sequence cut short by a byte that does not continue it
  task automatic send_text_unit(input int noise_pct, input int broken_pct);
    int          kind;
    int          len;
    int          conts;
    logic [31:0] r;
    logic [ByteW-1:0] b;
    kind = $urandom_range(99);
    len  = $urandom_range(1, 4);
    r    = $urandom;
    if (kind < noise_pct) begin
      send_byte(r[7:0], rand_last());
    end else begin
      case (len)
        1:       b = {1'b0, r[6:0]};
        2:       b = {3'b110, r[4:0]};
        3:       b = {4'b1110, r[3:0]};
        default: b = {5'b11110, r[2:0]};
      endcase
      send_byte(b, rand_last());
      if (kind < noise_pct + broken_pct && len > 1) begin
        conts = $urandom_range(0, len - 2);
        for (int i = 0; i < conts; i++) send_byte(rand_cont(), rand_last());
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_byte(b, rand_last());
      end else begin
        for (int i = 1; i < len; i++) send_byte(rand_cont(), rand_last());
      end
    end
  endtask

  // receiver stall, with an optional long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [CpW-1:0] want_v,
                                 input logic [CpW-1:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk_i) begin
    cp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cps.size() == 0) begin
        report_mismatch("unexpected code point", '0, code_point_o);
      end else begin
        want = pending_cps.pop_front();
        if (code_point_o !== want.cp) report_mismatch("code point", want.cp, code_point_o);
        if (run_end_o !== want.run_end)
          report_mismatch("run end", CpW'(want.run_end), CpW'(run_end_o));
        if (want.cp == ReplCp) repl_seen++;
        cps_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero byte and the top of the single-byte range
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // two, three and four byte forms, the last one giving 0x1fffff
  task automatic test_complete_sequences();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // stray continuation and bytes that can never lead
  task automatic test_malformed_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // sequence broken by a byte that is not a continuation, up to a full burst
  task automatic test_broken_sequences();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // end of text with a sequence open, also a broken one ending on a new lead
  task automatic test_end_of_text();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  // mostly well-formed text with random content, the rest noise and breaks
  task automatic test_random_text(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_text_unit(15, 15);
  endtask

  // long stretch with no idling on either side
  task automatic test_steady_stream(input int n_bytes);
    int target;
    gap_pct   = 0;
    stall_pct = 0;
    target    = bytes_sent + n_bytes;
    while (bytes_sent < target) send_text_unit(15, 15);
    gap_pct   = 31;
    stall_pct = 31;
  endtask

  // receiver holds off while error-heavy text keeps coming, so the result
  // register fills and the input side has to stall
  task automatic test_backpressure(input int n_bytes);
    int target;
    gap_pct   = 0;
    hold_left = 80;
    target    = bytes_sent + n_bytes;
    while (bytes_sent < target) send_text_unit(40, 40);
    gap_pct   = 31;
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_bytes();
    test_complete_sequences();
    test_malformed_leads();
    test_broken_sequences();
    test_end_of_text();
    test_random_text(150);
    test_steady_stream(100);
    test_backpressure(50);
    test_random_text(150);

    text_valid_i <= 1'b0;
    stall_pct = 31;
    // let every owed code point come out, then idle for a drain period
    while (pending_cps.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (pending_cps.size() != 0) begin
      errors++;
      $display("%0t: %0d code points never arrived", $time, pending_cps.size());
    end

    $display("run covered %0d bytes: directed cases, random text, a steady stream",
             bytes_sent);
    $display("and a long hold-off; %0d code points checked, %0d replacements, %0d errors",
             cps_checked, repl_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
